// File: sv/ravt_pkg.sv
// shared types, codes and defaults of the alarm vote table
`timescale 1ns / 1ps

package ravt_pkg;

  // default geometry of the table
  localparam int MAX_SECTIONS_DEF    = 8;
  localparam int MAX_TYPES_DEF       = 4;
  localparam int MAX_VOTERS_DEF      = 4;
  localparam int SEVERITY_LEVELS_DEF = 8;

  // opcodes of an input word
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SECTIONS = 2'd0;
  localparam logic [1:0] CFG_TYPES    = 2'd1;
  localparam logic [1:0] CFG_VOTERS   = 2'd2;

  // write status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_VOTER = 3'd1;
  localparam logic [2:0] ST_BAD_SECT  = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_SEV   = 3'd4;

  // change classes of a cell
  localparam logic [2:0] CH_NONE    = 3'd0;
  localparam logic [2:0] CH_CLEARED = 3'd1;
  localparam logic [2:0] CH_NEW     = 3'd2;
  localparam logic [2:0] CH_RAISED  = 3'd3;
  localparam logic [2:0] CH_LOWERED = 3'd4;

  // what the result register loads
  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_DONE   = 2'd1,
    EMIT_STATUS = 2'd2,
    EMIT_CELL   = 2'd3
  } emit_e;

  // commands from controller to datapath
  typedef struct packed {
    logic  latch;
    logic  clear;
    logic  scan_init;
    logic  scan_next;
    logic  rd_wsel;
    logic  mem_wr;
    logic  lvl_wr;
    emit_e emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic wr_ok;
    logic scan_last;
  } stat_t;

endpackage

// File: sv/ravt_ctrl.sv
// sequencer for write, evaluate and clear operations
`timescale 1ns / 1ps

module ravt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          opcode_i,
  input  ravt_pkg::stat_t     stat_i,
  output ravt_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_W_READ  = 6'b000010,
    S_W_WRITE = 6'b000100,
    S_E_READ  = 6'b001000,
    S_E_CHECK = 6'b010000,
    S_E_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.emit    = ravt_pkg::EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (opcode_i)
            ravt_pkg::OP_WRITE: begin
              if (stat_i.wr_ok) begin
                state_d = S_W_READ;
              end else begin
                cmd_o.emit = ravt_pkg::EMIT_STATUS;
              end
            end
            ravt_pkg::OP_EVAL: begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_E_READ;
            end
            ravt_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = ravt_pkg::EMIT_DONE;
            end
            default: begin
              cmd_o.emit = ravt_pkg::EMIT_DONE;
            end
          endcase
        end
      end
      S_W_READ: begin
        cmd_o.rd_wsel = 1'b1;
        state_d       = S_W_WRITE;
      end
      S_W_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.emit   = ravt_pkg::EMIT_DONE;
        state_d      = S_IDLE;
      end
      S_E_READ: begin
        state_d = S_E_CHECK;
      end
      S_E_CHECK: begin
        cmd_o.emit   = ravt_pkg::EMIT_CELL;
        cmd_o.lvl_wr = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_E_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_E_READ;
        end
      end
      S_E_DONE: begin
        cmd_o.emit = ravt_pkg::EMIT_DONE;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: sv/ravt_datapath.sv
// vote memory, cell severities, scan counters and result register
`timescale 1ns / 1ps

module ravt_datapath #(
  parameter int MAX_SECTIONS    = ravt_pkg::MAX_SECTIONS_DEF,
  parameter int MAX_TYPES       = ravt_pkg::MAX_TYPES_DEF,
  parameter int MAX_VOTERS      = ravt_pkg::MAX_VOTERS_DEF,
  parameter int SEVERITY_LEVELS = ravt_pkg::SEVERITY_LEVELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ravt_pkg::cmd_t  cmd_i,
  output ravt_pkg::stat_t stat_o,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [3:0]      cfg_data_i,
  input  logic [2:0]      voter_i,
  input  logic [3:0]      section_in_i,
  input  logic [2:0]      alarm_kind_in_i,
  input  logic [3:0]      vote_severity_i,
  output logic            out_valid_o,
  output logic [2:0]      section_out_o,
  output logic [1:0]      alarm_kind_out_o,
  output logic [2:0]      new_level_o,
  output logic [2:0]      old_level_o,
  output logic [2:0]      change_kind_o,
  output logic            disagree_o,
  output logic [2:0]      status_o,
  output logic            last_o
);

  localparam int CELLS = MAX_SECTIONS * MAX_TYPES;
  localparam int LW    = (SEVERITY_LEVELS > 1) ? $clog2(SEVERITY_LEVELS) : 1;
  localparam int SW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int TW    = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int VW    = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef logic [MAX_VOTERS-1:0][LW-1:0] row_t;

  // configuration registers
  logic [3:0] act_sec_q;
  logic [2:0] act_typ_q;
  logic [2:0] act_vot_q;

  // clamped active counts
  logic [4:0] ns, nt, nv;

  // latched write word
  logic [CW-1:0] wr_cell_q;
  logic [VW-1:0] wr_voter_q;
  logic [LW-1:0] wr_sev_q;

  // scan counters
  logic [SW-1:0] scan_s_q;
  logic [TW-1:0] scan_t_q;
  logic [CW-1:0] scan_cell;

  // vote memory, one row of votes per cell
  row_t          mem_q [CELLS];
  logic [CELLS-1:0] row_vld_q;
  row_t          rd_row_q;
  logic          rd_vld_q;
  row_t          row_eff;
  row_t          row_new;
  logic [CW-1:0] rd_addr;

  // cell severities
  logic [LW-1:0] cell_lvl_q [CELLS];

  // write checks and cell evaluation
  logic [2:0]    wr_status;
  logic [CW-1:0] in_cell;
  logic [LW-1:0] mx, old_lvl;
  logic          dis;
  logic [2:0]    ch;
  logic [15:0]   mx_ext, old_ext, sec_ext;

  function automatic logic [4:0] clamp_cnt(logic [4:0] v, logic [4:0] top);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > top) begin
      r = top;
    end
    return r;
  endfunction

  assign ns = clamp_cnt({1'b0, act_sec_q}, 5'(MAX_SECTIONS));
  assign nt = clamp_cnt({2'b0, act_typ_q}, 5'(MAX_TYPES));
  assign nv = clamp_cnt({2'b0, act_vot_q}, 5'(MAX_VOTERS));

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_sec_q <= 4'd8;
      act_typ_q <= 3'd4;
      act_vot_q <= 3'd4;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ravt_pkg::CFG_SECTIONS: act_sec_q <= cfg_data_i;
        ravt_pkg::CFG_TYPES:    act_typ_q <= cfg_data_i[2:0];
        ravt_pkg::CFG_VOTERS:   act_vot_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // range checks in priority order
  always_comb begin
    if ({2'b0, voter_i} >= nv) begin
      wr_status = ravt_pkg::ST_BAD_VOTER;
    end else if ({1'b0, section_in_i} >= ns) begin
      wr_status = ravt_pkg::ST_BAD_SECT;
    end else if ({2'b0, alarm_kind_in_i} >= nt) begin
      wr_status = ravt_pkg::ST_BAD_TYPE;
    end else if ({1'b0, vote_severity_i} >= 5'(SEVERITY_LEVELS)) begin
      wr_status = ravt_pkg::ST_BAD_SEV;
    end else begin
      wr_status = ravt_pkg::ST_OK;
    end
  end

  assign in_cell = CW'(({4'b0, section_in_i} * 8'(MAX_TYPES)) + {5'b0, alarm_kind_in_i});

  // latch write word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      wr_cell_q  <= in_cell;
      wr_voter_q <= VW'(voter_i);
      wr_sev_q   <= LW'(vote_severity_i);
    end
  end

  // scan position, section-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_s_q <= '0;
      scan_t_q <= '0;
    end else if (cmd_i.scan_init) begin
      scan_s_q <= '0;
      scan_t_q <= '0;
    end else if (cmd_i.scan_next) begin
      if (5'(scan_t_q) + 5'd1 == nt) begin
        scan_t_q <= '0;
        scan_s_q <= scan_s_q + SW'(1);
      end else begin
        scan_t_q <= scan_t_q + TW'(1);
      end
    end
  end

  assign scan_cell = CW'((8'(scan_s_q) * 8'(MAX_TYPES)) + 8'(scan_t_q));
  assign stat_o.scan_last = (5'(scan_s_q) + 5'd1 == ns) && (5'(scan_t_q) + 5'd1 == nt);
  assign stat_o.wr_ok     = (wr_status == ravt_pkg::ST_OK);

  // memory read and write
  assign rd_addr = cmd_i.rd_wsel ? wr_cell_q : scan_cell;

  always_ff @(posedge clk_i) begin
    rd_row_q <= mem_q[rd_addr];
    if (cmd_i.mem_wr) begin
      mem_q[wr_cell_q] <= row_new;
    end
  end

  // row valid bits stand in for the zeroed table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr];
      if (cmd_i.clear) begin
        row_vld_q <= '0;
      end else if (cmd_i.mem_wr) begin
        row_vld_q[wr_cell_q] <= 1'b1;
      end
    end
  end

  assign row_eff = rd_vld_q ? rd_row_q : '0;

  // insert one vote into the row
  always_comb begin
    row_new             = row_eff;
    row_new[wr_voter_q] = wr_sev_q;
  end

  // cell severities
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_lvl_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_lvl_q[i] <= '0;
      end
    end else if (cmd_i.lvl_wr) begin
      cell_lvl_q[scan_cell] <= mx;
    end
  end

  assign old_lvl = cell_lvl_q[scan_cell];

  // maximum vote and disagreement over active voters
  always_comb begin
    mx  = row_eff[0];
    dis = 1'b0;
    for (int v = 1; v < MAX_VOTERS; v++) begin
      if (5'(v) < nv) begin
        if (row_eff[v] != row_eff[0]) begin
          dis = 1'b1;
        end
        if (row_eff[v] > mx) begin
          mx = row_eff[v];
        end
      end
    end
  end

  // change class
  always_comb begin
    ch = ravt_pkg::CH_NONE;
    if (mx != old_lvl) begin
      if (mx == '0) begin
        ch = ravt_pkg::CH_CLEARED;
      end else if (old_lvl == '0) begin
        ch = ravt_pkg::CH_NEW;
      end else if (mx > old_lvl) begin
        ch = ravt_pkg::CH_RAISED;
      end else begin
        ch = ravt_pkg::CH_LOWERED;
      end
    end
  end

  assign mx_ext  = 16'(mx);
  assign old_ext = 16'(old_lvl);
  assign sec_ext = 16'(scan_s_q);

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      case (cmd_i.emit) inside
        ravt_pkg::EMIT_DONE, ravt_pkg::EMIT_STATUS: out_valid_o <= 1'b1;
        ravt_pkg::EMIT_CELL: out_valid_o <= (ch != ravt_pkg::CH_NONE) || dis;
        default: out_valid_o <= 1'b0;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    case (cmd_i.emit) inside
      ravt_pkg::EMIT_DONE, ravt_pkg::EMIT_STATUS: begin
        section_out_o    <= '0;
        alarm_kind_out_o <= '0;
        new_level_o      <= '0;
        old_level_o      <= '0;
        change_kind_o    <= ravt_pkg::CH_NONE;
        disagree_o       <= 1'b0;
        status_o         <= (cmd_i.emit == ravt_pkg::EMIT_STATUS) ? wr_status
                                                                  : ravt_pkg::ST_OK;
        last_o           <= 1'b1;
      end
      ravt_pkg::EMIT_CELL: begin
        section_out_o    <= sec_ext[2:0];
        alarm_kind_out_o <= 2'(scan_t_q);
        new_level_o      <= mx_ext[2:0];
        old_level_o      <= old_ext[2:0];
        change_kind_o    <= ch;
        disagree_o       <= dis;
        status_o         <= ravt_pkg::ST_OK;
        last_o           <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/redundant_alarm_vote_table.sv
// top level of the redundant alarm vote table
`timescale 1ns / 1ps

// Usage:
// A command word (opcode_i plus vote location and severity) is taken at a
// rising edge with start_i high and busy_o low. Results leave on the result
// ports for one cycle each, marked by out_valid_o; the receiver cannot stall,
// so every strobed word is final. last_o marks the final word of a command.
// Configuration registers (sections, types, voters in use) are written over
// cfg_valid_i/cfg_ready_o (always high) with cfg_index_i and cfg_data_i;
// the user must write them only while idle, the block does not enforce it.
// Clear, unknown opcodes and rejected writes report in the cycle after
// acceptance; an accepted write goes through row read, row rewrite and
// report, the read-modify-write of the vote memory. Evaluate does a
// memory read, then max and compare over the row, for each active cell
// (sections by types), then reports done. A new command may start in the
// cycle its last word is strobed.
// Reset clears the table at once through per-row valid bits: no sweep.
module redundant_alarm_vote_table #(
  parameter int MAX_SECTIONS    = ravt_pkg::MAX_SECTIONS_DEF,
  parameter int MAX_TYPES       = ravt_pkg::MAX_TYPES_DEF,
  parameter int MAX_VOTERS      = ravt_pkg::MAX_VOTERS_DEF,
  parameter int SEVERITY_LEVELS = ravt_pkg::SEVERITY_LEVELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] opcode_i,
  input  logic [2:0] voter_i,
  input  logic [3:0] section_in_i,
  input  logic [2:0] alarm_kind_in_i,
  input  logic [3:0] vote_severity_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output logic       out_valid_o,
  output logic [2:0] section_out_o,
  output logic [1:0] alarm_kind_out_o,
  output logic [2:0] new_level_o,
  output logic [2:0] old_level_o,
  output logic [2:0] change_kind_o,
  output logic       disagree_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  ravt_pkg::cmd_t  cmd;
  ravt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  // controller
  ravt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath
  ravt_datapath #(
    .MAX_SECTIONS    (MAX_SECTIONS),
    .MAX_TYPES       (MAX_TYPES),
    .MAX_VOTERS      (MAX_VOTERS),
    .SEVERITY_LEVELS (SEVERITY_LEVELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .voter_i          (voter_i),
    .section_in_i     (section_in_i),
    .alarm_kind_in_i  (alarm_kind_in_i),
    .vote_severity_i  (vote_severity_i),
    .out_valid_o      (out_valid_o),
    .section_out_o    (section_out_o),
    .alarm_kind_out_o (alarm_kind_out_o),
    .new_level_o      (new_level_o),
    .old_level_o      (old_level_o),
    .change_kind_o    (change_kind_o),
    .disagree_o       (disagree_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
